FILE: rtl/core/bsac_pkg.sv
package bsac_pkg;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int NUM_COEF = 6;
  localparam int CFG_IDX_W = 3;
  localparam int TEMP_W  = 15;
  localparam int PRESS_W = 17;

  localparam int DT_W   = 26;
  localparam int TW     = 22;
  localparam int A_W    = 40;
  localparam int B_W    = 26;
  localparam int MAG_B_W = B_W - 1;
  localparam int PROD_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_SENS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_TEMP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TEMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SLOPE  = 3'd5;

  localparam logic signed [TW-1:0] TEMP_REF  = 22'sd2000;
  localparam logic signed [TW-1:0] TEMP_COLD = -22'sd1500;
  localparam logic signed [TW-1:0] TEMP_MIN  = -22'sd4000;
  localparam logic signed [TW-1:0] TEMP_MAX  = 22'sd8500;
  localparam logic signed [PROD_W-1:0] PRESS_MAX = 64'sd131071;

  localparam int SH_TEMP  = 23;
  localparam int SH_OFF   = 7;
  localparam int SH_SENS  = 8;
  localparam int SH_T2    = 31;
  localparam int SH_PMUL  = 21;
  localparam int SH_PRESS = 15;

  typedef struct packed {
    logic                  start;
    logic signed [A_W-1:0] a;
    logic signed [B_W-1:0] b;
  } mul_req_t;

endpackage

FILE: rtl/core/baro_sample_average_compensate.sv
// Barometer sample averaging and second-order compensation. Raw temperature
// (in_tuser 0) and pressure (in_tuser 1) conversions each enter a moving-average
// ring of TEMP_DEPTH / PRESS_DEPTH entries, cleared at reset. A temperature item
// only enters its ring and gives no result. A pressure item gives one result:
// temperature in 0.01 C and pressure in 0.01 mbar, both saturated. A pressure
// item occupies the block through serial summing and bit-serial division of
// both rings, then a chain of multiplies: four at or above 20.00 C, six below
// it and seven below -15.00 C, with a separate fix-up state for the cold
// correction. No new input is taken until the result is in the output register;
// the shared shift-add multiplier handles one multiplier bit per cycle.
// Calibration words are to be written through cfg_we / cfg_addr / cfg_wdata
// with the block idle; the block itself does not enforce this.
module baro_sample_average_compensate #(
  parameter int TEMP_DEPTH  = 4,
  parameter int PRESS_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [23:0]                         in_tdata,   // raw_value[23:0]
  input  logic                                in_tuser,   // mode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // temp_centi[14:0], press_centi[31:15]
  input  logic                                cfg_we,
  input  logic [bsac_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [bsac_pkg::COEF_W-1:0]         cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_AVG, S_MGO, S_MWAIT, S_FIX, S_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    OP_TC6, OP_OFF, OP_SENS, OP_T2, OP_Q, OP_R, OP_P
  } mul_op_t;

  localparam int TW  = bsac_pkg::TW;
  localparam int A_W = bsac_pkg::A_W;
  localparam int B_W = bsac_pkg::B_W;
  localparam int PW  = bsac_pkg::PROD_W;

  seq_state_t                         state_r;
  mul_op_t                            op_r;
  logic [bsac_pkg::COEF_W-1:0]        coef_r [bsac_pkg::NUM_COEF];
  logic signed [bsac_pkg::DT_W-1:0]   dt_r;
  logic signed [TW-1:0]               temp_r;
  logic signed [TW-1:0]               t2_r;
  logic signed [A_W-1:0]              off_r;
  logic signed [A_W-1:0]              sens_r;
  logic [bsac_pkg::PRESS_W-1:0]       press_r;
  logic                               out_tvalid_r;
  logic [31:0]                        out_tdata_r;

  logic                               in_acc;
  logic                               t_busy, p_busy, mul_busy;
  logic [bsac_pkg::RAW_W-1:0]         t_mean, p_mean;
  bsac_pkg::mul_req_t                 mreq;
  logic signed [PW-1:0]               prod;

  logic signed [26:0]                 dt_wide;
  logic signed [TW-1:0]               dcold, dvery;
  logic signed [A_W-1:0]              c_a [bsac_pkg::NUM_COEF];
  logic signed [A_W-1:0]              q_half, q_quart, r_val, r_half;
  logic signed [PW-1:0]               px_diff, px;
  logic [bsac_pkg::PRESS_W-1:0]       press_sat;
  logic signed [TW-1:0]               temp_sat;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    for (int i = 0; i < bsac_pkg::NUM_COEF; i++) begin
      c_a[i] = signed'({{(A_W - bsac_pkg::COEF_W){1'b0}}, coef_r[i]});
    end
  end

  assign dt_wide = signed'({3'b000, t_mean})
                 - signed'({3'b000, coef_r[bsac_pkg::CFG_REF_TEMP], 8'h00});
  assign dcold   = temp_r - bsac_pkg::TEMP_REF;
  assign dvery   = temp_r - bsac_pkg::TEMP_COLD;
  assign q_half  = A_W'(prod >>> 1);
  assign q_quart = A_W'(prod >>> 2);
  assign r_val   = A_W'(prod);
  assign r_half  = A_W'(prod >>> 1);
  assign px_diff = (prod >>> bsac_pkg::SH_PMUL) - PW'(off_r);
  assign px      = px_diff >>> bsac_pkg::SH_PRESS;

  always_comb begin
    if (px < 0) begin
      press_sat = '0;
    end else if (px > bsac_pkg::PRESS_MAX) begin
      press_sat = '1;
    end else begin
      press_sat = px[bsac_pkg::PRESS_W-1:0];
    end
    if (temp_r < bsac_pkg::TEMP_MIN) begin
      temp_sat = bsac_pkg::TEMP_MIN;
    end else if (temp_r > bsac_pkg::TEMP_MAX) begin
      temp_sat = bsac_pkg::TEMP_MAX;
    end else begin
      temp_sat = temp_r;
    end
  end

  always_comb begin
    mreq.start = (state_r == S_MGO);
    mreq.a     = A_W'(dt_r);
    mreq.b     = B_W'(dt_r);
    unique case (op_r)
      OP_TC6:  mreq.a = c_a[bsac_pkg::CFG_TEMP_SLOPE];
      OP_OFF:  mreq.a = c_a[bsac_pkg::CFG_OFFSET_TEMP];
      OP_SENS: mreq.a = c_a[bsac_pkg::CFG_SENS_TEMP];
      OP_T2:   mreq.a = A_W'(dt_r);
      OP_Q: begin
        mreq.a = A_W'(dcold);
        mreq.b = B_W'(dcold);
      end
      OP_R: begin
        mreq.a = A_W'(dvery);
        mreq.b = B_W'(dvery);
      end
      OP_P: begin
        mreq.a = sens_r;
        mreq.b = signed'({2'b00, p_mean});
      end
      default: mreq.a = A_W'(dt_r);
    endcase
  end

  bsac_avg #(.DEPTH(TEMP_DEPTH)) u_temp_avg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && !in_tuser),
    .wr_data (in_tdata),
    .start   (in_acc && in_tuser),
    .busy    (t_busy),
    .mean    (t_mean)
  );

  bsac_avg #(.DEPTH(PRESS_DEPTH)) u_press_avg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && in_tuser),
    .wr_data (in_tdata),
    .start   (in_acc && in_tuser),
    .busy    (p_busy),
    .mean    (p_mean)
  );

  bsac_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .busy  (mul_busy),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bsac_pkg::NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_addr < 3'(bsac_pkg::NUM_COEF))) begin
      coef_r[cfg_addr] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= OP_TC6;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_tuser) begin
            state_r <= S_AVG;
          end
        end
        S_AVG: begin
          if (!t_busy && !p_busy) begin
            dt_r    <= bsac_pkg::DT_W'(dt_wide);
            op_r    <= OP_TC6;
            state_r <= S_MGO;
          end
        end
        S_MGO: begin
          state_r <= S_MWAIT;
        end
        S_MWAIT: begin
          if (!mul_busy) begin
            unique case (op_r)
              OP_TC6: begin
                temp_r  <= TW'(prod >>> bsac_pkg::SH_TEMP) + bsac_pkg::TEMP_REF;
                op_r    <= OP_OFF;
                state_r <= S_MGO;
              end
              OP_OFF: begin
                off_r   <= signed'({8'h00, coef_r[bsac_pkg::CFG_OFFSET], 16'h0000})
                         + A_W'(prod >>> bsac_pkg::SH_OFF);
                op_r    <= OP_SENS;
                state_r <= S_MGO;
              end
              OP_SENS: begin
                sens_r  <= signed'({9'h000, coef_r[bsac_pkg::CFG_SENS], 15'h0000})
                         + A_W'(prod >>> bsac_pkg::SH_SENS);
                op_r    <= (temp_r < bsac_pkg::TEMP_REF) ? OP_T2 : OP_P;
                state_r <= S_MGO;
              end
              OP_T2: begin
                t2_r    <= TW'(prod >>> bsac_pkg::SH_T2);
                op_r    <= OP_Q;
                state_r <= S_MGO;
              end
              OP_Q: begin
                off_r  <= off_r - ((q_half <<< 2) + q_half);
                sens_r <= sens_r - ((q_quart <<< 2) + q_quart);
                if (temp_r < bsac_pkg::TEMP_COLD) begin
                  op_r    <= OP_R;
                  state_r <= S_MGO;
                end else begin
                  state_r <= S_FIX;
                end
              end
              OP_R: begin
                off_r   <= off_r - ((r_val <<< 3) - r_val);
                sens_r  <= sens_r - ((r_half <<< 3) + (r_half <<< 1) + r_half);
                state_r <= S_FIX;
              end
              OP_P: begin
                press_r <= press_sat;
                state_r <= S_OUT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_FIX: begin
          temp_r  <= temp_r - t2_r;
          op_r    <= OP_P;
          state_r <= S_MGO;
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {press_r, temp_sat[bsac_pkg::TEMP_W-1:0]};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/bsac_avg.sv
module bsac_avg #(
  parameter int DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [bsac_pkg::RAW_W-1:0]  wr_data,
  input  logic                        start,
  output logic                        busy,
  output logic [bsac_pkg::RAW_W-1:0]  mean
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = bsac_pkg::RAW_W + IW;
  localparam int RW = $clog2(DEPTH + 1) + 1;
  localparam int CW = $clog2(SW + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [RW-1:0] DIVISOR  = RW'(DEPTH);
  localparam logic [CW-1:0] LAST_BIT = CW'(SW - 1);

  typedef enum logic [1:0] {A_IDLE, A_SUM, A_DIV} avg_state_t;

  avg_state_t                  state_r;
  logic [bsac_pkg::RAW_W-1:0]  ring_r [DEPTH];
  logic [IW-1:0]               slot_r;
  logic [IW-1:0]               idx_r;
  logic [SW-1:0]               sum_r;
  logic [RW-1:0]               rem_r;
  logic [CW-1:0]               cnt_r;
  logic [bsac_pkg::RAW_W-1:0]  mean_r;

  logic [RW-1:0] trial;
  logic          qbit;
  logic [SW-1:0] shift_nxt;

  assign trial     = {rem_r[RW-2:0], sum_r[SW-1]};
  assign qbit      = (trial >= DIVISOR);
  assign shift_nxt = {sum_r[SW-2:0], qbit};
  assign busy      = (state_r != A_IDLE);
  assign mean      = mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      slot_r  <= '0;
      state_r <= A_IDLE;
    end else begin
      if (wr_en) begin
        ring_r[slot_r] <= wr_data;
        slot_r         <= (slot_r == LAST_IDX) ? '0 : slot_r + 1'b1;
      end
      unique case (state_r)
        A_IDLE: begin
          if (start) begin
            sum_r   <= '0;
            idx_r   <= '0;
            state_r <= A_SUM;
          end
        end
        A_SUM: begin
          sum_r <= sum_r + SW'(ring_r[idx_r]);
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= A_DIV;
          end
        end
        A_DIV: begin
          sum_r <= shift_nxt;
          rem_r <= qbit ? trial - DIVISOR : trial;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_BIT) begin
            mean_r  <= shift_nxt[bsac_pkg::RAW_W-1:0];
            state_r <= A_IDLE;
          end
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/bsac_mul.sv
module bsac_mul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bsac_pkg::mul_req_t                    req,
  output logic                                  busy,
  output logic signed [bsac_pkg::PROD_W-1:0]    prod
);

  localparam int CW = $clog2(bsac_pkg::MAG_B_W);
  localparam logic [CW-1:0] LAST_BIT = CW'(bsac_pkg::MAG_B_W - 1);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_SIGN} mul_state_t;

  mul_state_t                           state_r;
  logic [bsac_pkg::PROD_W-1:0]          mcand_r;
  logic [bsac_pkg::MAG_B_W-1:0]         mplier_r;
  logic [bsac_pkg::PROD_W-1:0]          acc_r;
  logic                                 neg_r;
  logic [CW-1:0]                        cnt_r;
  logic signed [bsac_pkg::PROD_W-1:0]   prod_r;

  logic [bsac_pkg::A_W-1:0] mag_a;
  logic [bsac_pkg::B_W-1:0] mag_b;

  assign mag_a = req.a[bsac_pkg::A_W-1] ? -req.a : req.a;
  assign mag_b = req.b[bsac_pkg::B_W-1] ? -req.b : req.b;
  assign busy  = (state_r != M_IDLE);
  assign prod  = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      unique case (state_r)
        M_IDLE: begin
          if (req.start) begin
            mcand_r  <= bsac_pkg::PROD_W'(mag_a);
            mplier_r <= mag_b[bsac_pkg::MAG_B_W-1:0];
            acc_r    <= '0;
            neg_r    <= req.a[bsac_pkg::A_W-1] ^ req.b[bsac_pkg::B_W-1];
            cnt_r    <= '0;
            state_r  <= M_RUN;
          end
        end
        M_RUN: begin
          if (mplier_r[0]) begin
            acc_r <= acc_r + mcand_r;
          end
          mcand_r  <= {mcand_r[bsac_pkg::PROD_W-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[bsac_pkg::MAG_B_W-1:1]};
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == LAST_BIT) begin
            state_r <= M_SIGN;
          end
        end
        M_SIGN: begin
          prod_r  <= neg_r ? -signed'(acc_r) : signed'(acc_r);
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

endmodule

FILE: dv/baro_sample_average_compensate_tb.sv
`timescale 1ns / 100ps
module baro_sample_average_compensate_tb;

  typedef struct packed {
    logic        mode;
    logic [23:0] raw;
  } sample_t;

  typedef struct packed {
    logic [16:0]        press;
    logic signed [14:0] temp;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [bsac_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [bsac_pkg::COEF_W-1:0] cfg_wdata = '0;

  sample_t pending_q[$];
  reading_t readings_q[$];
  logic [15:0] cal[6];
  logic [23:0] t_ring[4];
  logic [23:0] p_ring[4];
  logic [1:0] t_slot, p_slot;
  int fails = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_cycles = 0;
  int stall_phase = 0;

  always #1 clk = ~clk;

  baro_sample_average_compensate u_top (.*);

  function automatic longint floor_shift(longint x, int s);
    return x >>> s;
  endfunction

  function automatic void compensate(sample_t s);
    longint d1, d2, dt, tc, off, sens, q, r, off2, sens2, t2, pr;
    logic [25:0] acc;
    reading_t res;
    if (s.mode == 1'b0) begin
      t_ring[t_slot] = s.raw;
      t_slot = t_slot + 2'd1;
      return;
    end
    p_ring[p_slot] = s.raw;
    p_slot = p_slot + 2'd1;
    acc = t_ring[0] + t_ring[1] + t_ring[2] + t_ring[3];
    d2 = longint'(acc >> 2);
    acc = p_ring[0] + p_ring[1] + p_ring[2] + p_ring[3];
    d1 = longint'(acc >> 2);
    dt = d2 - longint'(cal[bsac_pkg::CFG_REF_TEMP]) * 256;
    tc = 2000 + floor_shift(dt * longint'(cal[bsac_pkg::CFG_TEMP_SLOPE]),
                            bsac_pkg::SH_TEMP);
    off = longint'(cal[bsac_pkg::CFG_OFFSET]) * 65536
          + floor_shift(longint'(cal[bsac_pkg::CFG_OFFSET_TEMP]) * dt, bsac_pkg::SH_OFF);
    sens = longint'(cal[bsac_pkg::CFG_SENS]) * 32768
           + floor_shift(longint'(cal[bsac_pkg::CFG_SENS_TEMP]) * dt, bsac_pkg::SH_SENS);
    if (tc < 2000) begin
      q = (tc - 2000) * (tc - 2000);
      t2 = (dt * dt) >>> bsac_pkg::SH_T2;
      off2 = 5 * (q >>> 1);
      sens2 = 5 * (q >>> 2);
      if (tc < -1500) begin
        r = (tc + 1500) * (tc + 1500);
        off2 += 7 * r;
        sens2 += 11 * (r >>> 1);
      end
      tc -= t2;
      off -= off2;
      sens -= sens2;
    end
    pr = floor_shift(floor_shift(d1 * sens, bsac_pkg::SH_PMUL) - off, bsac_pkg::SH_PRESS);
    if (tc < -4000) tc = -4000;
    if (tc > 8500) tc = 8500;
    if (pr < 0) pr = 0;
    if (pr > 131071) pr = 131071;
    res.temp = tc[14:0];
    res.press = pr[16:0];
    readings_q.push_back(res);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        compensate(pending_q.pop_front());
      end
      if ((!in_tvalid || in_tready) || !rst_n) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() > (in_tvalid && in_tready ? 0 : 0) &&
                     pending_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tuser <= pending_q[0].mode;
          in_tdata <= pending_q[0].raw;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reading_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (readings_q.size() == 0) begin
          $display("%0t: unexpected reading, actual %h", $time, out_tdata);
          fails++;
        end else begin
          want = readings_q.pop_front();
          if (got.temp !== want.temp) begin
            $display("%0t: temp expected %0d actual %0d", $time, want.temp, got.temp);
            fails++;
          end
          if (got.press !== want.press) begin
            $display("%0t: press expected %0d actual %0d", $time, want.press,
                     got.press);
            fails++;
          end
        end
      end
      stall_phase <= stall_phase + 1;
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else if (stall_phase % 500 < 200) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic write_cal(logic [bsac_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    cal[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_tvalid || readings_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic load_cal(int kind);
    logic [15:0] v[6];
    for (int i = 0; i < 6; i++) begin
      case (kind)
        0: v[i] = 16'hFFFF;
        1: v[i] = 16'h0000;
        default: v[i] = 16'($urandom_range(0, 65535));
      endcase
    end
    if (kind == 2) begin
      v[bsac_pkg::CFG_SENS] = 16'($urandom_range(30000, 60000));
      v[bsac_pkg::CFG_OFFSET] = 16'($urandom_range(30000, 60000));
      v[bsac_pkg::CFG_SENS_TEMP] = 16'($urandom_range(20000, 40000));
      v[bsac_pkg::CFG_OFFSET_TEMP] = 16'($urandom_range(20000, 40000));
      v[bsac_pkg::CFG_REF_TEMP] = 16'($urandom_range(25000, 40000));
      v[bsac_pkg::CFG_TEMP_SLOPE] = 16'($urandom_range(20000, 35000));
    end
    for (int i = 0; i < 6; i++) write_cal(bsac_pkg::CFG_IDX_W'(i), v[i]);
  endtask

  task automatic add_random(int n, logic [15:0] c5);
    sample_t s;
    int base;
    for (int i = 0; i < n; i++) begin
      s.mode = $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 5))
        0: s.raw = 24'($urandom());
        1: s.raw = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
        default: begin
          base = s.mode ? 9000000 : int'(c5) * 256;
          s.raw = 24'(base + int'($urandom_range(0, 4000000)) - 2000000);
        end
      endcase
      pending_q.push_back(s);
    end
  endtask

  initial begin
    sample_t s;
    foreach (t_ring[i]) begin
      t_ring[i] = '0;
      p_ring[i] = '0;
    end
    foreach (cal[i]) cal[i] = '0;
    t_slot = '0;
    p_slot = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed
    s = '{1'b1, 24'h000000}; pending_q.push_back(s);
    s = '{1'b1, 24'hFFFFFF}; pending_q.push_back(s);
    drain();
    load_cal(0);
    for (int i = 0; i < 4; i++) begin
      s = '{1'b0, 24'hFFFFFF}; pending_q.push_back(s);
    end
    s = '{1'b1, 24'hFFFFFF}; pending_q.push_back(s);
    s = '{1'b1, 24'h000000}; pending_q.push_back(s);
    for (int i = 0; i < 4; i++) begin
      s = '{1'b0, 24'h000000}; pending_q.push_back(s);
    end
    s = '{1'b1, 24'h800000}; pending_q.push_back(s);
    s = '{1'b1, 24'h555555}; pending_q.push_back(s);
    s = '{1'b0, 24'hAAAAAA}; pending_q.push_back(s);
    s = '{1'b1, 24'hAAAAAA}; pending_q.push_back(s);
    drain();
    // long receiver hold-off while the sender keeps going
    hold_cycles = 3000;
    add_random(40, cal[bsac_pkg::CFG_REF_TEMP]);
    drain();
    for (int phase = 0; phase < 8; phase++) begin
      load_cal(phase == 0 ? 1 : (phase == 7 ? 0 : 2));
      add_random(200, cal[bsac_pkg::CFG_REF_TEMP]);
      drain();
    end
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("simulation failed");
    $finish;
  end

endmodule
